/* src/utf8sv_pkg.sv */
// ----------------------------------------------------------------------------
// utf8sv_pkg
// Shared types and constants for the UTF-8 stream validator.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8sv_pkg;

  // Verdict codes on encoding_kind
  localparam logic [1:0] KIND_ASCII  = 2'd0;
  localparam logic [1:0] KIND_UTF8   = 2'd1;
  localparam logic [1:0] KIND_SINGLE = 2'd2;

  localparam int unsigned CodeWidth = 21;

  // Lower bounds and upper bound of a decoded code point, by sequence length
  localparam logic [CodeWidth-1:0] MIN_TWO_BYTE   = 21'h00080;
  localparam logic [CodeWidth-1:0] MIN_THREE_BYTE = 21'h00800;
  localparam logic [CodeWidth-1:0] MIN_FOUR_BYTE  = 21'h10000;
  localparam logic [CodeWidth-1:0] MAX_CODE       = 21'h10FFFF;

  // Open sequence length codes
  localparam logic [1:0] SEQ_NONE  = 2'd0;
  localparam logic [1:0] SEQ_TWO   = 2'd1;
  localparam logic [1:0] SEQ_THREE = 2'd2;
  localparam logic [1:0] SEQ_FOUR  = 2'd3;

  // One input item as held in the input register
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       is_last;
  } item_t;

  // Decoder state carried from byte to byte
  typedef struct packed {
    logic [1:0]           bytes_left;
    logic [CodeWidth-1:0] partial_code;
    logic [1:0]           sequence_length;
    logic                 saw_high_byte;
    logic                 failed_flag;
  } dec_state_t;

  // Verdict travelling from the decoder to the output register
  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
  } verdict_t;

endpackage

`default_nettype wire

/* src/utf8_stream_validator_unit.sv */
// Path: the last item of a string passes the input register, the decoder and
//   the result register, which holds the verdict until it transfers.
// Throughput: one byte per cycle while the result register can take a last
//   item's verdict, set by the single decode step between the two registers.
// Reset: rst_ni clears both stage valid flags and all decoder state at once.
// ----------------------------------------------------------------------------
// utf8_stream_validator_unit
// Classifies a byte stream as ASCII, valid UTF-8 or single-byte text.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_validator_unit
  import utf8sv_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       byte_present_i,
  input  wire logic       is_last_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      encoding_kind_o
);

  item_t    in_item, s1_item;
  logic     s1_valid;
  logic     out_free;
  logic     dn_ready;
  logic     fire;
  verdict_t verdict;

  always_comb begin
    in_item.data_byte    = data_byte_i;
    in_item.byte_present = byte_present_i;
    in_item.is_last      = is_last_i;
  end

  // A non-last item never needs the result register
  assign dn_ready = !s1_item.is_last || out_free;
  assign fire     = s1_valid && dn_ready;

  utf8sv_input_stage u_input (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .dn_ready_i (dn_ready),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  utf8sv_decoder u_decoder (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .item_i    (s1_item),
    .verdict_o (verdict)
  );

  utf8sv_output_stage u_output (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .verdict_i       (verdict),
    .free_o          (out_free),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .encoding_kind_o (encoding_kind_o)
  );

endmodule

`default_nettype wire

/* src/utf8sv_input_stage.sv */
// ----------------------------------------------------------------------------
// utf8sv_input_stage
// Input register: captures one item per transfer and holds it until the
// decoder takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8sv_input_stage
  import utf8sv_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire item_t item_i,
  input  wire logic  dn_ready_i,
  output logic       valid_o,
  output item_t      item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  advance;

  // Release the held item when downstream can take it
  assign advance    = valid_q && dn_ready_i;
  assign in_ready_o = !valid_q || advance;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load payload on each input transfer
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

/* src/utf8sv_decoder.sv */
// ----------------------------------------------------------------------------
// utf8sv_decoder
// Per-byte UTF-8 checker: updates the sequence state and forms the verdict
// on the last item of a string.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8sv_decoder
  import utf8sv_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  fire_i,
  input  wire item_t item_i,
  output verdict_t   verdict_o
);

  dec_state_t state_q, state_d, upd;
  logic [7:0] b;
  logic       seq_ok;
  logic [CodeWidth-1:0] code_next;

  assign b = item_i.data_byte;

  // Shift in six payload bits of a continuation byte
  assign code_next = {state_q.partial_code[CodeWidth-7:0], b[5:0]};

  // Range check of a completed sequence
  always_comb begin
    case (state_q.sequence_length)
      SEQ_TWO:   seq_ok = (code_next >= MIN_TWO_BYTE);
      SEQ_THREE: seq_ok = (code_next >= MIN_THREE_BYTE);
      default:   seq_ok = (code_next >= MIN_FOUR_BYTE) && (code_next <= MAX_CODE);
    endcase
  end

  // Advance the state by one byte
  always_comb begin
    upd = state_q;
    if (item_i.byte_present && !state_q.failed_flag) begin
      if (state_q.bytes_left != 2'd0) begin
        if (b[7:6] != 2'b10) begin
          upd.failed_flag = 1'b1;
        end else begin
          upd.partial_code = code_next;
          upd.bytes_left   = state_q.bytes_left - 2'd1;
          if (state_q.bytes_left == 2'd1) begin
            if (!seq_ok) begin
              upd.failed_flag = 1'b1;
            end
            upd.partial_code    = '0;
            upd.sequence_length = SEQ_NONE;
          end
        end
      end else if (b[7]) begin
        upd.saw_high_byte = 1'b1;
        if (b[7:5] == 3'b110) begin
          upd.partial_code    = {{(CodeWidth-5){1'b0}}, b[4:0]};
          upd.sequence_length = SEQ_TWO;
          upd.bytes_left      = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          upd.partial_code    = {{(CodeWidth-4){1'b0}}, b[3:0]};
          upd.sequence_length = SEQ_THREE;
          upd.bytes_left      = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          upd.partial_code    = {{(CodeWidth-3){1'b0}}, b[2:0]};
          upd.sequence_length = SEQ_FOUR;
          upd.bytes_left      = 2'd3;
        end else begin
          upd.failed_flag = 1'b1;
        end
      end
    end
  end

  // Form the verdict; clear the state after the last item
  always_comb begin
    verdict_o.valid = fire_i && item_i.is_last;
    if (upd.failed_flag || (upd.bytes_left != 2'd0)) begin
      verdict_o.kind = KIND_SINGLE;
    end else if (upd.saw_high_byte) begin
      verdict_o.kind = KIND_UTF8;
    end else begin
      verdict_o.kind = KIND_ASCII;
    end

    state_d = state_q;
    if (fire_i) begin
      state_d = item_i.is_last ? '0 : upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* src/utf8sv_output_stage.sv */
// ----------------------------------------------------------------------------
// utf8sv_output_stage
// Result register: holds one verdict until the output transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8sv_output_stage
  import utf8sv_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire verdict_t verdict_i,
  output logic          free_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output logic [1:0]    encoding_kind_o
);

  logic       valid_q, valid_d;
  logic [1:0] kind_q;

  // Free when empty or being drained this cycle
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = verdict_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load a new verdict
  always_ff @(posedge clk_i) begin
    if (verdict_i.valid && free_o) begin
      kind_q <= verdict_i.kind;
    end
  end

  assign out_valid_o     = valid_q;
  assign encoding_kind_o = kind_q;

endmodule

`default_nettype wire

/* tb/tb_utf8_stream_validator_unit.sv */
// ----------------------------------------------------------------------------
// tb_utf8_stream_validator_unit
// Drives strings through the UTF-8 stream validator one item per transfer,
// predicts each verdict from its own decoder and compares it with the block.
// ----------------------------------------------------------------------------

module tb_utf8_stream_validator_unit;
  import utf8sv_pkg::*;

  // Track decoder state over accepted bytes and hold the verdicts still due
  class verdict_tracker;
    logic [1:0]  left     = '0;
    logic [20:0] code     = '0;
    logic [1:0]  seq_len  = SEQ_NONE;
    bit          saw_high = 1'b0;
    bit          failed   = 1'b0;
    logic [1:0]  verdict_q[$];
    int unsigned errors   = 0;

    function void clear();
      left     = '0;
      code     = '0;
      seq_len  = SEQ_NONE;
      saw_high = 1'b0;
      failed   = 1'b0;
    endfunction

    function bit code_in_range();
      case (seq_len)
        SEQ_TWO:   return code >= MIN_TWO_BYTE;
        SEQ_THREE: return code >= MIN_THREE_BYTE;
        default:   return code >= MIN_FOUR_BYTE && code <= MAX_CODE;
      endcase
    endfunction

    function void decode_byte(logic [7:0] b);
      // Ignore everything after a failure until the string ends
      if (failed) return;
      // Continuation expected: gather six bits or fail
      if (left != 2'd0) begin
        if (b[7:6] != 2'b10) begin
          failed = 1'b1;
          return;
        end
        code = {code[14:0], b[5:0]};
        left = left - 2'd1;
        if (left == 2'd0) begin
          if (!code_in_range()) failed = 1'b1;
          code    = '0;
          seq_len = SEQ_NONE;
        end
        return;
      end
      if (!b[7]) return;
      // Lead byte: open a sequence or fail on a bad lead
      saw_high = 1'b1;
      if (b[7:5] == 3'b110) begin
        code    = {16'd0, b[4:0]};
        seq_len = SEQ_TWO;
        left    = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        code    = {17'd0, b[3:0]};
        seq_len = SEQ_THREE;
        left    = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        code    = {18'd0, b[2:0]};
        seq_len = SEQ_FOUR;
        left    = 2'd3;
      end else begin
        failed = 1'b1;
      end
    endfunction

    function void note_item(logic [7:0] b, bit present, bit last);
      if (present) decode_byte(b);
      if (last) begin
        if (failed || left != 2'd0) verdict_q.push_back(KIND_SINGLE);
        else if (saw_high)          verdict_q.push_back(KIND_UTF8);
        else                        verdict_q.push_back(KIND_ASCII);
        clear();
      end
    endfunction

    function void check_verdict(logic [1:0] kind);
      logic [1:0] want;
      if (verdict_q.size() == 0) begin
        $error("encoding_kind: expected none, actual %0d", kind);
        errors++;
        return;
      end
      want = verdict_q.pop_front();
      if (kind !== want) begin
        $error("encoding_kind: expected %0d, actual %0d", want, kind);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic [7:0] data_byte_i    = 8'h00;
  logic       byte_present_i = 1'b0;
  logic       is_last_i      = 1'b0;
  logic       out_ready_i    = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [1:0] encoding_kind_o;

  verdict_tracker board;
  bit             calm = 1'b0;
  int unsigned    bytes_sent = 0;
  logic [8:0]     str_q[$];

  utf8_stream_validator_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .byte_present_i  (byte_present_i),
    .is_last_i       (is_last_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .encoding_kind_o (encoding_kind_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Check each verdict transfer and stall the result side now and then
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_verdict(encoding_kind_o);
    out_ready_i <= calm || ($urandom_range(99) >= 6);
  end

  // Offer one item, hold it until the transfer, then note it
  task automatic send_item(logic [7:0] b, bit present, bit last);
    while (!calm && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    data_byte_i    <= b;
    byte_present_i <= present;
    is_last_i      <= last;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_item(b, present, last);
    bytes_sent++;
  endtask

  // Send n bytes packed first-byte-highest as one string
  task automatic send_seq(int n, logic [31:0] bytes);
    for (int i = n - 1; i >= 0; i--) send_item(bytes[i*8 +: 8], 1'b1, i == 0);
  endtask

  // Append the first keep bytes of an n-byte encoding of cp
  task automatic add_seq(int n, logic [20:0] cp, int keep);
    logic [7:0] enc[4];
    case (n)
      2: begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {2'b10, cp[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {2'b10, cp[11:6]};
        enc[2] = {2'b10, cp[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++) str_q.push_back({1'b1, enc[i]});
  endtask

  task automatic add_valid_seq();
    int n;
    n = $urandom_range(2, 4);
    case (n)
      2:       add_seq(2, $urandom_range(21'h80, 21'h7FF), 2);
      3:       add_seq(3, $urandom_range(21'h800, 21'hFFFF), 3);
      default: add_seq(4, $urandom_range(21'h10000, 21'h10FFFF), 4);
    endcase
  endtask

  // Append one piece of a string; broken pieces only where allowed
  task automatic add_token(int mode);
    int r;
    int n;
    r = $urandom_range(99);
    if (mode == 0 || r < 35) begin
      if (mode == 0 && r < 5) str_q.push_back({1'b0, 8'($urandom_range(255))});
      else                    str_q.push_back({1'b1, 8'($urandom_range(127))});
    end else if (mode == 1 || r < 65) begin
      if (r < 95) add_valid_seq();
      else        str_q.push_back({1'b0, 8'($urandom_range(255))});
    end else begin
      n = $urandom_range(2, 4);
      if (r < 71) begin
        // Overlong form
        case (n)
          2:       add_seq(2, $urandom_range(21'h0, 21'h7F), 2);
          3:       add_seq(3, $urandom_range(21'h0, 21'h7FF), 3);
          default: add_seq(4, $urandom_range(21'h0, 21'hFFFF), 4);
        endcase
      end else if (r < 76) begin
        add_seq(4, $urandom_range(21'h110000, 21'h1FFFFF), 4);
      end else if (r < 82) begin
        // Sequence cut short, then whatever follows
        add_seq(n, $urandom_range(21'h0, 21'h1FFFFF), $urandom_range(1, n - 1));
      end else if (r < 88) begin
        str_q.push_back({1'b1, 8'($urandom_range(255))});
      end else if (r < 94) begin
        str_q.push_back({1'b1, 8'($urandom_range(8'hF8, 8'hFF))});
      end else begin
        str_q.push_back({1'b0, 8'($urandom_range(255))});
      end
    end
  endtask

  task automatic send_random_string();
    int mode;
    int pieces;
    int r;
    r = $urandom_range(99);
    mode = (r < 15) ? 0 : (r < 70) ? 1 : 2;
    pieces = $urandom_range(0, 6);
    str_q.delete();
    for (int i = 0; i < pieces; i++) add_token(mode);
    if (str_q.size() == 0 || $urandom_range(99) < 15)
      str_q.push_back({1'b0, 8'($urandom_range(255))});
    foreach (str_q[i]) send_item(str_q[i][7:0], str_q[i][8], i == str_q.size() - 1);
  endtask

  initial begin
    int unsigned waited;
    board = new;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty string, ASCII extremes, boundaries and failure modes
    send_item(8'hA5, 1'b0, 1'b1);
    send_seq(2, 32'h007F);
    send_seq(2, 32'hC280);
    send_seq(2, 32'hC1BF);
    send_seq(3, 32'hE09FBF);
    send_seq(3, 32'hEDA080);
    send_seq(4, 32'hF4908080);
    send_seq(4, 32'hF48FBFBF);
    send_seq(1, 32'hFF);
    send_seq(2, 32'hC241);
    send_seq(2, 32'hE282);
    send_item(8'hC2, 1'b1, 1'b0);
    send_item(8'h3C, 1'b0, 1'b1);

    // Random strings, with one stretch free of gaps and stalls
    while (bytes_sent < 1850) begin
      calm = (bytes_sent > 700 && bytes_sent < 1000);
      send_random_string();
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    // Drain remaining verdicts, then allow for the pipeline latency
    waited = 0;
    while (board.verdict_q.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (board.verdict_q.size() != 0) begin
      $error("encoding_kind: expected %0d more, actual none", board.verdict_q.size());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("[utf8_stream_validator_unit] OK");
    end else begin
      $display("[utf8_stream_validator_unit] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("[utf8_stream_validator_unit] ERROR");
    $finish;
  end

endmodule

/* filelist.f */
src/utf8sv_pkg.sv
src/utf8sv_input_stage.sv
src/utf8sv_decoder.sv
src/utf8sv_output_stage.sv
src/utf8_stream_validator_unit.sv
tb/tb_utf8_stream_validator_unit.sv
